/* rtl/dss_pkg.sv */
// Shared types and constants for the dual stack shared store unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_PEEK    = 2'd2,
    OP_REPLACE = 2'd3
  } dss_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOTFOUND  = 2'd3
  } dss_status_e;

  // One result word as it travels from the core to the output register.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    dss_status_e       status;
  } dss_res_t;

endpackage

`default_nettype wire

/* rtl/dss_core.sv */
// Sequencer, shared store and compare unit of the dual stack shared store unit.
// Depends on dss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dss_core #(
  parameter int unsigned DEPTH = dss_pkg::DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 op_i,
  input  wire logic                       stack_sel_i,
  input  wire logic [dss_pkg::DATA_W-1:0] value_i,
  input  wire logic [dss_pkg::DATA_W-1:0] new_value_i,
  output logic                            res_valid_o,
  output dss_pkg::dss_res_t               res_o,
  input  wire logic                       res_take_i
);
  import dss_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e            state_q, state_d;
  dss_op_e           op_in;
  logic [DATA_W-1:0] value_q, value_d;
  logic [DATA_W-1:0] new_value_q, new_value_d;
  logic [CW-1:0]     lc_q, lc_d;
  logic [CW-1:0]     hc_q, hc_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     last_q, last_d;
  logic [AW-1:0]     cmp_idx_q, cmp_idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic              issue_done_q, issue_done_d;
  dss_res_t          res_q, res_d;

  // Store ports.
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata;

  logic              full;
  logic              sel_empty;
  logic [CW-1:0]     top_w;
  logic [CW-1:0]     hpush_w;
  logic [CW-1:0]     lc_dec;
  logic [CW-1:0]     hc_inc;

  assign op_in     = dss_op_e'(op_i);
  assign full      = ({1'b0, lc_q} + {1'b0, hc_q}) >= {1'b0, DEPTH_C};
  assign sel_empty = stack_sel_i ? (hc_q == '0) : (lc_q == '0);
  assign lc_dec    = lc_q - CW'(1);
  assign hc_inc    = hc_q + CW'(1);
  assign top_w     = stack_sel_i ? (DEPTH_C - hc_q) : lc_dec;
  assign hpush_w   = DEPTH_C - hc_inc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_RESULT);
  assign res_o       = res_q;

  always_comb begin
    state_d      = state_q;
    value_d      = value_q;
    new_value_d  = new_value_q;
    lc_d         = lc_q;
    hc_d         = hc_q;
    idx_d        = idx_q;
    last_d       = last_q;
    cmp_idx_d    = cmp_idx_q;
    cmp_vld_d    = cmp_vld_q;
    issue_done_d = issue_done_q;
    res_d        = res_q;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = '0;
    raddr        = idx_q;
    wdata        = value_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          value_d     = value_i;
          new_value_d = new_value_i;
          res_d.data  = '0;
          res_d.status = ST_OK;
          unique case (op_in)
            OP_PUSH: begin
              state_d = S_RESULT;
              if (full) begin
                res_d.status = ST_OVERFLOW;
              end else if (stack_sel_i) begin
                we    = 1'b1;
                waddr = hpush_w[AW-1:0];
                hc_d  = hc_inc;
              end else begin
                we    = 1'b1;
                waddr = lc_q[AW-1:0];
                lc_d  = lc_q + CW'(1);
              end
            end
            OP_POP, OP_PEEK: begin
              if (sel_empty) begin
                res_d.status = ST_UNDERFLOW;
                state_d      = S_RESULT;
              end else begin
                re      = 1'b1;
                raddr   = top_w[AW-1:0];
                state_d = S_READ;
                if (op_in == OP_POP) begin
                  if (stack_sel_i) begin
                    hc_d = hc_q - CW'(1);
                  end else begin
                    lc_d = lc_dec;
                  end
                end
              end
            end
            OP_REPLACE: begin
              if (sel_empty) begin
                res_d.status = ST_NOTFOUND;
                state_d      = S_RESULT;
              end else begin
                // Low stack scans from entry 0 up to its top; high stack
                // scans from its top up to the last entry.
                idx_d        = stack_sel_i ? top_w[AW-1:0] : '0;
                last_d       = stack_sel_i ? AW'(DEPTH - 1) : lc_dec[AW-1:0];
                cmp_vld_d    = 1'b0;
                issue_done_d = 1'b0;
                state_d      = S_SCAN;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_READ: begin
        res_d.data   = rd_q;
        res_d.status = ST_OK;
        state_d      = S_RESULT;
      end

      S_SCAN: begin
        // One read is issued per cycle; the compare works on the word
        // read in the previous cycle.
        if (cmp_vld_q && (rd_q == value_q)) begin
          we           = 1'b1;
          waddr        = cmp_idx_q;
          wdata        = new_value_q;
          res_d.status = ST_OK;
          state_d      = S_RESULT;
        end else if (cmp_vld_q && (cmp_idx_q == last_q)) begin
          res_d.status = ST_NOTFOUND;
          state_d      = S_RESULT;
        end else if (!issue_done_q) begin
          re        = 1'b1;
          raddr     = idx_q;
          cmp_idx_d = idx_q;
          cmp_vld_d = 1'b1;
          if (idx_q == last_q) begin
            issue_done_d = 1'b1;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end else begin
          cmp_vld_d = 1'b0;
        end
      end

      S_RESULT: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      value_q      <= '0;
      new_value_q  <= '0;
      lc_q         <= '0;
      hc_q         <= '0;
      idx_q        <= '0;
      last_q       <= '0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      issue_done_q <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      value_q      <= value_d;
      new_value_q  <= new_value_d;
      lc_q         <= lc_d;
      hc_q         <= hc_d;
      idx_q        <= idx_d;
      last_q       <= last_d;
      cmp_idx_q    <= cmp_idx_d;
      cmp_vld_q    <= cmp_vld_d;
      issue_done_q <= issue_done_d;
      res_q        <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/dss_out_reg.sv */
// Output register of the dual stack shared store unit: holds one result word
// until the receiver takes it. Depends on dss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dss_out_reg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       res_valid_i,
  input  wire dss_pkg::dss_res_t          res_i,
  output logic                            res_take_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [dss_pkg::DATA_W-1:0]      data_o,
  output logic [1:0]                      status_o
);
  import dss_pkg::*;

  logic     valid_q, valid_d;
  dss_res_t word_q, word_d;

  // The register can load whenever it is empty or its word leaves this cycle.
  assign res_take_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (res_take_o) begin
      valid_d = res_valid_i;
      if (res_valid_i) begin
        word_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      word_q  <= '0;
    end else begin
      valid_q <= valid_d;
      word_q  <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign data_o      = word_q.data;
  assign status_o    = word_q.status;

endmodule

`default_nettype wire

/* rtl/dual_stack_shared_store_unit.sv */
// Top level of the dual stack shared store unit: two stacks in one store.
// Depends on dss_pkg, dss_core and dss_out_reg.
//
//   channel | direction | handshake               | fields
//   --------+-----------+-------------------------+------------------------------------
//   in      | input     | in_valid_i / in_stall_o | op_i, stack_sel_i, value_i, new_value_i
//   out     | output    | out_valid_o / out_stall_i | data_o, status_o
//
// Push and every failed operation go from acceptance straight to the result
// register; pop and peek first pass through one registered store read.
// Replace scans the selected stack with one store read per cycle, each word
// compared against the search value in the cycle after it is read.
// Reset clears both stack counts; store contents are not cleared.
// A stalled output word stays in the output register while the next word
// is accepted; the core waits only when a second result is ready.
`timescale 1ns / 1ps
`default_nettype none

module dual_stack_shared_store_unit #(
  parameter int unsigned DEPTH = dss_pkg::DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        op_i,
  input  wire logic                              stack_sel_i,
  input  wire logic signed [dss_pkg::DATA_W-1:0] value_i,
  input  wire logic signed [dss_pkg::DATA_W-1:0] new_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [dss_pkg::DATA_W-1:0]      data_o,
  output logic [1:0]                             status_o
);
  import dss_pkg::*;

  logic     res_valid;
  logic     res_take;
  dss_res_t res;
  logic [DATA_W-1:0] data_w;

  dss_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .stack_sel_i(stack_sel_i),
    .value_i    (value_i),
    .new_value_i(new_value_i),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_take_i (res_take)
  );

  dss_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .res_take_o (res_take),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .data_o     (data_w),
    .status_o   (status_o)
  );

  assign data_o = data_w;

endmodule

`default_nettype wire

/* rtl/dss_checker.sv */
// Port-level checks for the dual stack shared store unit, bound to the top.
// Depends on dss_pkg and dual_stack_shared_store_unit.
`timescale 1ns / 1ps
`default_nettype none

module dss_port_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [dss_pkg::DATA_W-1:0] data_o,
  input wire logic [1:0]                 status_o
);
  import dss_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_o) && $stable(status_o))
    else $error("stalled result word changed");

  // Every accepted word keeps the block busy: the input stalls in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // A new result only appears after the core stalled its input with a word in flight.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a word in flight");

  // Failed operations return zero data.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (data_o == '0))
    else $error("failed operation returned nonzero data");

endmodule

bind dual_stack_shared_store_unit dss_port_checker u_dss_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .data_o     (data_o),
  .status_o   (status_o)
);

`default_nettype wire
